@@ rtl/core/bfsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types, command codes and saturating arithmetic for the shortest
// path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int VTX_W   = 4;
  localparam int CNT_W   = VTX_W + 1;
  localparam int CFG_W   = 5;
  localparam int WGT_W   = 16;
  localparam int DIST_W  = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic [VTX_W-1:0]        tail;
    logic [VTX_W-1:0]        head;
    logic signed [WGT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                     reach;
    logic signed [DIST_W-1:0] cost;
  } dist_t;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] addr;
    dist_t            data;
  } dist_wr_t;

  function automatic logic signed [DIST_W-1:0] sat_add(
    input logic signed [DIST_W-1:0] a,
    input logic signed [WGT_W-1:0]  w
  );
    logic signed [DIST_W:0] s;
    logic signed [DIST_W-1:0] r;
    s = {a[DIST_W-1], a} + {{(DIST_W+1-WGT_W){w[WGT_W-1]}}, w};
    if (s[DIST_W] != s[DIST_W-1]) begin
      r = s[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      r = s[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bfsp_edge_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_edge_mem
// Edge table: appends on add, empties on clear, registered read port.
// ----------------------------------------------------------------------------
module bfsp_edge_mem
  import bfsp_pkg::*;
#(
  parameter int MAX_EDGES = 256,
  parameter int EW        = $clog2(MAX_EDGES),
  parameter int CW        = $clog2(MAX_EDGES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  edge_t         wr_data,
  input  logic          clr,
  input  logic [EW-1:0] rd_addr,
  output edge_t         rd_data,
  output logic [CW-1:0] count
);

  edge_t         mem [MAX_EDGES];
  edge_t         rd_data_r;
  logic [CW-1:0] count_r;
  logic          room;

  assign room    = count_r < CW'(MAX_EDGES);
  assign rd_data = rd_data_r;
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[count_r[EW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clr) begin
      count_r <= '0;
    end else if (wr_en && room) begin
      count_r <= count_r + CW'(1);
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES))
    else $error("edge count beyond capacity");

endmodule

@@ rtl/core/bfsp_dist_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_dist_mem
// Per-vertex distance memory, two registered read ports and one write port.
// ----------------------------------------------------------------------------
module bfsp_dist_mem
  import bfsp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [VTX_W-1:0] rd_addr_a,
  input  logic [VTX_W-1:0] rd_addr_b,
  output dist_t            rd_data_a,
  output dist_t            rd_data_b,
  input  dist_wr_t         wr
);

  dist_t mem [DEPTH];
  dist_t rd_a_r;
  dist_t rd_b_r;

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a[AW-1:0]];
    rd_b_r <= mem[rd_addr_b[AW-1:0]];
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

endmodule

@@ rtl/core/bellman_ford_shortest_path.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Single-source shortest paths over a stored table of directed weighted edges.
// ----------------------------------------------------------------------------
// Add and clear requests are accepted while busy stays low. A run request
// holds busy while it initializes the distance memory, makes n-1 passes
// over the E stored edges (skipped when n is 1 or the table is empty), where
// n is the active vertex count, at one edge relaxation per cycle through the
// read-modify-write loop on the distance memory (with write forwarding),
// drains the relaxation pipeline, then reads each vertex. Results appear one
// per cycle on out_valid, each registered through the o1 and output stages
// after its read, with out_last on the final vertex; the receiver cannot stall them.
module bellman_ford_shortest_path
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic [VTX_W-1:0]         in_edge_from,
  input  logic [VTX_W-1:0]         in_edge_to,
  input  logic signed [WGT_W-1:0]  in_edge_weight,
  input  logic [VTX_W-1:0]         in_source_vertex,
  output logic                     out_valid,
  output logic [VTX_W-1:0]         out_vertex,
  output logic signed [DIST_W-1:0] out_distance,
  output logic                     out_reachable,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_num_vertices
);

  localparam int VCAP = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int NW   = $clog2(VCAP + 1);
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_EDGES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_RELAX = 5'b00100,
    S_DRAIN = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] nv_r;
  logic [NW-1:0]    n_act;
  logic [NW-1:0]    n_r, n_nxt;
  logic [VTX_W-1:0] src_r, src_nxt;
  logic [VTX_W-1:0] v_r, v_nxt;
  logic [EW-1:0]    e_r, e_nxt;
  logic [NW-1:0]    pass_r, pass_nxt;

  logic             accept;
  logic             v_last;
  logic             e_last;
  logic             pass_last;

  edge_t            edge_wr_data;
  edge_t            edge_rd_data;
  logic [CW-1:0]    edge_count;

  logic [VTX_W-1:0] rd_addr_a;
  dist_t            rd_a;
  dist_t            rd_b;
  dist_wr_t         dist_wr;

  logic             s1_valid_r;
  logic             s2_valid_r;
  edge_t            s2_edge_r;
  logic             fw_valid_r;
  logic [VTX_W-1:0] fw_addr_r;
  dist_t            fw_data_r;

  dist_t                    ta;
  dist_t                    tb;
  logic                     in_range;
  logic signed [DIST_W-1:0] cand;
  logic                     relax_upd;

  logic             o1_valid_r;
  logic [VTX_W-1:0] o1_v_r;
  logic             o1_last_r;

  logic                     out_valid_r;
  logic [VTX_W-1:0]         out_vertex_r;
  logic signed [DIST_W-1:0] out_distance_r;
  logic                     out_reachable_r;
  logic                     out_last_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (nv_r == '0) begin
      n_act = NW'(1);
    end else if (nv_r > CFG_W'(VCAP)) begin
      n_act = NW'(VCAP);
    end else begin
      n_act = NW'(nv_r);
    end
  end

  assign v_last    = (CNT_W'(v_r) + CNT_W'(1)) == CNT_W'(n_r);
  assign e_last    = (CW'(e_r) + CW'(1)) == edge_count;
  assign pass_last = (CNT_W'(pass_r) + CNT_W'(2)) == CNT_W'(n_r);

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    src_nxt   = src_r;
    v_nxt     = v_r;
    e_nxt     = e_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_RUN) begin
          n_nxt     = n_act;
          src_nxt   = in_source_vertex;
          v_nxt     = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        v_nxt = v_r + VTX_W'(1);
        if (v_last) begin
          v_nxt    = '0;
          e_nxt    = '0;
          pass_nxt = '0;
          if (n_r == NW'(1) || edge_count == '0) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_RELAX;
          end
        end
      end
      S_RELAX: begin
        e_nxt = e_r + EW'(1);
        if (e_last) begin
          e_nxt = '0;
          if (pass_last) begin
            state_nxt = S_DRAIN;
          end else begin
            pass_nxt = pass_r + NW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        v_nxt = v_r + VTX_W'(1);
        if (v_last) begin
          v_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nv_r        <= CFG_W'(16);
      n_r         <= NW'(1);
      src_r       <= '0;
      v_r         <= '0;
      e_r         <= '0;
      pass_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      o1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      src_r       <= src_nxt;
      v_r         <= v_nxt;
      e_r         <= e_nxt;
      pass_r      <= pass_nxt;
      s1_valid_r  <= (state_r == S_RELAX);
      s2_valid_r  <= s1_valid_r;
      fw_valid_r  <= relax_upd;
      o1_valid_r  <= (state_r == S_READ);
      out_valid_r <= o1_valid_r;
      if (cfg_valid && cfg_ready) begin
        nv_r <= cfg_num_vertices;
      end
    end
  end

  // edge table
  assign edge_wr_data = '{tail: in_edge_from, head: in_edge_to, weight: in_edge_weight};

  bfsp_edge_mem #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && in_cmd == CMD_ADD),
    .wr_data (edge_wr_data),
    .clr     (accept && in_cmd == CMD_CLEAR),
    .rd_addr (e_r),
    .rd_data (edge_rd_data),
    .count   (edge_count)
  );

  // distance memory
  assign rd_addr_a = (state_r == S_READ) ? v_r : edge_rd_data.tail;

  bfsp_dist_mem #(
    .DEPTH (VCAP)
  ) u_dist_mem (
    .clk       (clk),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (edge_rd_data.head),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr        (dist_wr)
  );

  // relaxation stage with forwarding of the previous write
  always_comb begin
    ta = (fw_valid_r && fw_addr_r == s2_edge_r.tail) ? fw_data_r : rd_a;
    tb = (fw_valid_r && fw_addr_r == s2_edge_r.head) ? fw_data_r : rd_b;
    in_range = (CNT_W'(s2_edge_r.tail) < CNT_W'(n_r)) &&
               (CNT_W'(s2_edge_r.head) < CNT_W'(n_r));
    cand = sat_add(ta.cost, s2_edge_r.weight);
    relax_upd = s2_valid_r && in_range && ta.reach &&
                (!tb.reach || ($signed(cand) < $signed(tb.cost)));
  end

  always_comb begin
    if (state_r == S_INIT) begin
      dist_wr.en         = 1'b1;
      dist_wr.addr       = v_r;
      dist_wr.data.reach = (v_r == src_r);
      dist_wr.data.cost  = '0;
    end else begin
      dist_wr.en         = relax_upd;
      dist_wr.addr       = s2_edge_r.head;
      dist_wr.data.reach = 1'b1;
      dist_wr.data.cost  = cand;
    end
  end

  always_ff @(posedge clk) begin
    s2_edge_r       <= edge_rd_data;
    fw_addr_r       <= s2_edge_r.head;
    fw_data_r.reach <= 1'b1;
    fw_data_r.cost  <= cand;
    o1_v_r          <= v_r;
    o1_last_r       <= v_last;
    out_vertex_r    <= o1_v_r;
    out_reachable_r <= rd_a.reach;
    out_distance_r  <= rd_a.reach ? rd_a.cost : '0;
    out_last_r      <= o1_last_r;
  end

  assign out_valid     = out_valid_r;
  assign out_vertex    = out_vertex_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;
  assign out_last      = out_last_r && out_valid_r;

  a_wr_source: assert property (@(posedge clk) disable iff (!rst_n)
    dist_wr.en |-> (state_r == S_INIT) || s2_valid_r)
    else $error("distance write outside init or relaxation");

  a_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !s1_valid_r && !s2_valid_r)
    else $error("result read while relaxation in flight");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_RUN) |=> (state_r == S_INIT))
    else $error("run request did not start initialization");

  a_last_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> $past(o1_valid_r) && $past(o1_last_r))
    else $error("last result without a final read");

endmodule
